// ----- src/kdl_pkg.sv -----
// Package of types, constants and look-up functions for the keypad door lock controller.
`default_nettype none
package kdl_pkg;

   localparam int unsigned CODE_LEN   = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CODE_DIGIT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_DIGIT_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_DIGIT_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_DIGIT_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD  = 3'd4;

   localparam logic [3:0] CODE_RESET_0 = 4'd0;
   localparam logic [3:0] CODE_RESET_1 = 4'd1;
   localparam logic [3:0] CODE_RESET_2 = 4'd0;
   localparam logic [3:0] CODE_RESET_3 = 4'd6;
   localparam logic [7:0] SCAN_PERIOD_RESET = 8'd5;

   localparam logic [3:0] KEY_A    = 4'd10;
   localparam logic [3:0] KEY_B    = 4'd11;
   localparam logic [3:0] KEY_C    = 4'd12;
   localparam logic [3:0] KEY_D    = 4'd13;
   localparam logic [3:0] KEY_STAR = 4'd14;
   localparam logic [3:0] KEY_HASH = 4'd15;

   localparam logic [7:0] FONT_UNDERSCORE = 8'h08;

   typedef logic [3:0] digit_type;

   function automatic logic [7:0] font_of(input digit_type d);
      logic [7:0] seg;
      case (d)
         4'd0, 4'd10: seg = 8'h3F;
         4'd1, 4'd11: seg = 8'h06;
         4'd2, 4'd12: seg = 8'h5B;
         4'd3, 4'd13: seg = 8'h4F;
         4'd4, 4'd14: seg = 8'h66;
         4'd5, 4'd15: seg = 8'h6D;
         4'd6:        seg = 8'h7D;
         4'd7:        seg = 8'h07;
         4'd8:        seg = 8'h7F;
         4'd9:        seg = 8'h6F;
         default:     seg = FONT_UNDERSCORE;
      endcase
      return seg;
   endfunction

   function automatic digit_type key_of(input logic [1:0] row, input logic [1:0] col);
      digit_type key;
      case ({row, col})
         4'b00_00: key = 4'd1;
         4'b00_01: key = 4'd2;
         4'b00_10: key = 4'd3;
         4'b00_11: key = KEY_A;
         4'b01_00: key = 4'd4;
         4'b01_01: key = 4'd5;
         4'b01_10: key = 4'd6;
         4'b01_11: key = KEY_B;
         4'b10_00: key = 4'd7;
         4'b10_01: key = 4'd8;
         4'b10_10: key = 4'd9;
         4'b10_11: key = KEY_C;
         4'b11_00: key = KEY_STAR;
         4'b11_01: key = 4'd0;
         4'b11_10: key = KEY_HASH;
         4'b11_11: key = KEY_D;
         default:  key = KEY_D;
      endcase
      return key;
   endfunction

endpackage
`default_nettype wire

// ----- src/kdl_req_if.sv -----
// Handshake channel carrying one keypad tick transaction.
`default_nettype none
interface kdl_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] col_mask;

   modport source (output valid, output col_mask, input ready);
   modport sink   (input valid, input col_mask, output ready);
endinterface
`default_nettype wire

// ----- src/kdl_rsp_if.sv -----
// Handshake channel carrying one display and status transaction.
`default_nettype none
interface kdl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments;
   logic [1:0] digit_select;
   logic [1:0] row_select;
   logic       green_led;
   logic       red_led;

   modport source (output valid, output segments, output digit_select, output row_select,
                   output green_led, output red_led, input ready);
   modport sink   (input valid, input segments, input digit_select, input row_select,
                   input green_led, input red_led, output ready);
endinterface
`default_nettype wire

// ----- src/keypad_door_lock_controller.sv -----
// Top level of the keypad door lock controller: display multiplexing, keypad scan and code check.
// A result transaction is presented in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle unless the downstream stalls; all state updates in a single pass on acceptance.
// A tick is refused only while a finished result is held back by the downstream ready.
// Synchronous active-high reset clears the entry, LEDs, scan and display counters.
// Reset also restores the unlock code to 0106 and the scan period to five ticks.
`default_nettype none
module keypad_door_lock_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   kdl_req_if.sink                               req_bus,
   kdl_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_wr_en,
   input  wire logic [kdl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [kdl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   kdl_pkg::digit_type code_ff [kdl_pkg::CODE_LEN];
   logic [7:0]         scan_period_ff;

   kdl_pkg::digit_type digits_ff [kdl_pkg::CODE_LEN];
   kdl_pkg::digit_type digits_in [kdl_pkg::CODE_LEN];
   logic [2:0] count_ff, count_in;
   logic [1:0] pos_ff, pos_in;
   logic [1:0] row_ff, row_in;
   logic [7:0] div_ff, div_in;
   logic       held_ff, held_in;
   logic       seen_ff, seen_in;
   logic       green_ff, green_in;
   logic       red_ff, red_in;

   logic       rsp_valid_ff;
   logic [7:0] seg_ff, seg_in;
   logic [1:0] dsel_ff;

   logic       req_accept;
   logic [8:0] div_next;
   logic       scan_tick;
   logic       key_found;
   logic [1:0] key_col;
   kdl_pkg::digit_type key;
   logic       match;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff[0]     <= kdl_pkg::CODE_RESET_0;
         code_ff[1]     <= kdl_pkg::CODE_RESET_1;
         code_ff[2]     <= kdl_pkg::CODE_RESET_2;
         code_ff[3]     <= kdl_pkg::CODE_RESET_3;
         scan_period_ff <= kdl_pkg::SCAN_PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            kdl_pkg::CSR_CODE_DIGIT_0: code_ff[0] <= csr_wdata[3:0];
            kdl_pkg::CSR_CODE_DIGIT_1: code_ff[1] <= csr_wdata[3:0];
            kdl_pkg::CSR_CODE_DIGIT_2: code_ff[2] <= csr_wdata[3:0];
            kdl_pkg::CSR_CODE_DIGIT_3: code_ff[3] <= csr_wdata[3:0];
            kdl_pkg::CSR_SCAN_PERIOD:  scan_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      key_found = 1'b0;
      key_col   = 2'd0;
      for (int c = 3; c >= 0; c--) begin
         if (req_bus.col_mask[c]) begin
            key_found = 1'b1;
            key_col   = 2'(c);
         end
      end
   end

   assign key      = kdl_pkg::key_of(row_ff, key_col);
   assign div_next = {1'b0, div_ff} + 9'd1;
   assign scan_tick = div_next >= {1'b0, scan_period_ff};

   always_comb begin
      match = (count_ff == 3'd4);
      for (int i = 0; i < kdl_pkg::CODE_LEN; i++) begin
         if (digits_ff[i] != code_ff[i]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      digits_in = digits_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      seen_in   = seen_ff;
      green_in  = green_ff;
      red_in    = red_ff;
      row_in    = row_ff;
      div_in    = div_next[7:0];
      pos_in    = pos_ff + 2'd1;

      if ({1'b0, pos_ff} < count_ff) begin
         seg_in = kdl_pkg::font_of(digits_ff[pos_ff]);
      end else begin
         seg_in = kdl_pkg::FONT_UNDERSCORE;
      end

      if (scan_tick) begin
         div_in = 8'd0;
         if (key_found) begin
            seen_in = 1'b1;
         end
         if (key_found && !held_ff) begin
            if (key < kdl_pkg::KEY_A) begin
               if (count_ff < 3'd4) begin
                  digits_in[count_ff[1:0]] = key;
                  count_in = count_ff + 3'd1;
               end
            end else if (key == kdl_pkg::KEY_STAR) begin
               for (int i = 0; i < kdl_pkg::CODE_LEN; i++) begin
                  digits_in[i] = 4'd0;
               end
               count_in = 3'd0;
               green_in = 1'b0;
               red_in   = 1'b0;
            end else if (key == kdl_pkg::KEY_HASH) begin
               green_in = match;
               red_in   = !match;
            end
            held_in = 1'b1;
         end
         row_in = row_ff + 2'd1;
         if (row_in == 2'd0) begin
            if (!seen_in) begin
               held_in = 1'b0;
            end
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kdl_pkg::CODE_LEN; i++) begin
            digits_ff[i] <= 4'd0;
         end
         count_ff     <= 3'd0;
         pos_ff       <= 2'd0;
         row_ff       <= 2'd0;
         div_ff       <= 8'd0;
         held_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         green_ff     <= 1'b0;
         red_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            digits_ff <= digits_in;
            count_ff  <= count_in;
            pos_ff    <= pos_in;
            row_ff    <= row_in;
            div_ff    <= div_in;
            held_ff   <= held_in;
            seen_ff   <= seen_in;
            green_ff  <= green_in;
            red_ff    <= red_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         seg_ff  <= seg_in;
         dsel_ff <= pos_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.segments     = seg_ff;
   assign rsp_bus.digit_select = dsel_ff;
   assign rsp_bus.row_select   = row_ff;
   assign rsp_bus.green_led    = green_ff;
   assign rsp_bus.red_led      = red_ff;

   a_leds_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(green_ff && red_ff))
      else $error("Both LEDs are lit at once.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("Entry count exceeds four digits.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(seg_ff) && $stable(pos_ff))
      else $error("A stalled result was overwritten.");

   a_display_advances: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (dsel_ff + 2'd1 == pos_ff))
      else $error("Display position did not advance with the transaction.");

endmodule
`default_nettype wire
